// File: design/tsla_pkg.sv
// Shared types and constants for the triangle strip/list assembler.
package tsla_pkg;

    localparam int unsigned INDEX_W  = 16;
    localparam int unsigned LIMIT_W  = 15;
    localparam int unsigned BASE_W   = 24;
    localparam int unsigned VERTEX_W = 25;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 24;

    localparam logic [INDEX_W-1:0] RESTART_INDEX     = 16'hFFFF;
    localparam logic [LIMIT_W-1:0] MAX_PART_VERTICES = 15'd20000;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET       = 15'd1;

    localparam logic [CFG_IDX_W-1:0] REG_ASSEMBLY_MODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_VERTEX_LIMIT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BASE_VERTEX   = 2'd2;

    localparam logic MODE_LIST  = 1'b0;
    localparam logic MODE_STRIP = 1'b1;

    typedef struct packed {
        logic [INDEX_W-1:0] index_value;
        logic               part_start;
    } tsla_in_t;

    typedef struct packed {
        logic [VERTEX_W-1:0] first_vertex;
        logic [VERTEX_W-1:0] second_vertex;
        logic [VERTEX_W-1:0] third_vertex;
    } tsla_out_t;

endpackage

// File: design/triangle_strip_list_assembler.sv
// Top level: triangle list / strip primitive assembler with restart.
// Accepts one vertex index per clock on the idx channel and emits at most one triangle per
// index on the prim channel, passing the input register and then the result
// register. Sustained rate is one index per cycle, set by the update of the
// held-index history between the two registers; a stalled result only blocks new indices
// once both registers are full. Configuration writes are taken every cycle and should only
// be issued while no index is in flight.
module triangle_strip_list_assembler
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          idx_valid,
    output logic                          idx_ready,
    input  tsla_pkg::tsla_in_t            idx_beat,
    output logic                          prim_valid,
    input  logic                          prim_ready,
    output tsla_pkg::tsla_out_t           prim_beat,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [tsla_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tsla_pkg::CFG_DATA_W-1:0] cfg_data
);
    import tsla_pkg::*;

    logic                 mode_reg;
    logic [LIMIT_W-1:0]   vertex_limit_reg;
    logic [BASE_W-1:0]    base_vertex_reg;

    logic                 in_valid_reg;
    tsla_in_t             in_beat_reg;

    logic [INDEX_W-1:0]   older_reg, older_next;
    logic [INDEX_W-1:0]   newer_reg, newer_next;
    logic [1:0]           held_count_reg, held_count_next;
    logic                 parity_reg, parity_next;

    logic                 prim_valid_reg;
    tsla_out_t            prim_beat_reg, prim_beat_next;
    logic                 emit_next;

    logic                 advance;
    logic                 limit_ok;
    logic                 ix_ok, older_ok, newer_ok;
    logic [INDEX_W-1:0]   ix;
    logic [INDEX_W-1:0]   va, vb;
    logic [1:0]           cnt;
    logic                 par;

    assign cfg_ready  = 1'b1;
    assign advance    = in_valid_reg && (!prim_valid_reg || prim_ready);
    assign idx_ready  = !in_valid_reg || advance;
    assign prim_valid = prim_valid_reg;
    assign prim_beat  = prim_beat_reg;

    assign ix       = in_beat_reg.index_value;
    assign limit_ok = (vertex_limit_reg != '0) && (vertex_limit_reg <= MAX_PART_VERTICES);
    assign ix_ok    = limit_ok && (ix < {1'b0, vertex_limit_reg});
    assign older_ok = limit_ok && (older_reg < {1'b0, vertex_limit_reg});
    assign newer_ok = limit_ok && (newer_reg < {1'b0, vertex_limit_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg         <= MODE_LIST;
            vertex_limit_reg <= LIMIT_RESET;
            base_vertex_reg  <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_ASSEMBLY_MODE: mode_reg         <= cfg_data[0];
                REG_VERTEX_LIMIT:  vertex_limit_reg <= cfg_data[LIMIT_W-1:0];
                REG_BASE_VERTEX:   base_vertex_reg  <= cfg_data[BASE_W-1:0];
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        cnt             = in_beat_reg.part_start ? 2'd0 : held_count_reg;
        par             = in_beat_reg.part_start ? 1'b0 : parity_reg;
        older_next      = older_reg;
        newer_next      = newer_reg;
        held_count_next = cnt;
        parity_next     = par;
        emit_next       = 1'b0;
        va              = older_reg;
        vb              = newer_reg;
        if (mode_reg == MODE_LIST)
        begin
            if (cnt < 2'd2)
            begin
                if (cnt == 2'd0)
                    older_next = ix;
                else
                    newer_next = ix;
                held_count_next = cnt + 2'd1;
            end
            else
            begin
                held_count_next = 2'd0;
                emit_next       = older_ok && newer_ok && ix_ok;
            end
        end
        else if (ix == RESTART_INDEX || !ix_ok)
        begin
            held_count_next = 2'd0;
            parity_next     = 1'b0;
        end
        else if (cnt < 2'd2)
        begin
            if (cnt == 2'd0)
                older_next = ix;
            else
                newer_next = ix;
            held_count_next = cnt + 2'd1;
        end
        else
        begin
            emit_next   = (older_reg != newer_reg) && (newer_reg != ix) && (older_reg != ix);
            va          = par ? newer_reg : older_reg;
            vb          = par ? older_reg : newer_reg;
            older_next  = newer_reg;
            newer_next  = ix;
            parity_next = !par;
        end
        prim_beat_next.first_vertex  = {1'b0, base_vertex_reg} + {9'd0, va};
        prim_beat_next.second_vertex = {1'b0, base_vertex_reg} + {9'd0, vb};
        prim_beat_next.third_vertex  = {1'b0, base_vertex_reg} + {9'd0, ix};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            prim_valid_reg <= 1'b0;
            older_reg      <= '0;
            newer_reg      <= '0;
            held_count_reg <= 2'd0;
            parity_reg     <= 1'b0;
        end
        else
        begin
            if (idx_ready)
                in_valid_reg <= idx_valid;
            if (advance)
            begin
                older_reg      <= older_next;
                newer_reg      <= newer_next;
                held_count_reg <= held_count_next;
                parity_reg     <= parity_next;
                prim_valid_reg <= emit_next;
            end
            else if (prim_ready)
                prim_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (idx_valid && idx_ready)
            in_beat_reg <= idx_beat;
        if (advance && emit_next)
            prim_beat_reg <= prim_beat_next;
    end

`ifndef SYNTH
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        held_count_reg != 2'd3)
        else $error("held count out of range");

    a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        prim_valid_reg && !prim_ready |=> prim_valid_reg && $stable(prim_beat_reg))
        else $error("stalled triangle lost or changed");

    a_part_start: assert property (@(posedge clk) disable iff (!rst_n)
        advance && in_beat_reg.part_start |=> held_count_reg <= 2'd1)
        else $error("part start did not clear history");

    a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !in_valid_reg |-> idx_ready)
        else $error("input register empty but not ready");
`endif

endmodule
